@@ rtl/slb_pkg.sv @@
// Package for the spectrum band log averager: widths, item and state types, constants.
// No dependencies; every other file of the block imports it.
package slb_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int FRAME_CFG_W  = 17;
  localparam int GROUP_CFG_W  = 13;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int BAND_W       = 16;
  localparam int LEVEL_W      = 18;
  localparam int LEVEL_FRAC_W = 8;

  // Magnitude carries 4 fraction bits: root of (re^2 + im^2) * 256.
  localparam int MAG_W = SAMPLE_W + 4;
  localparam int RAD_W = 2 * MAG_W;
  localparam int SQ_W  = 2 * SAMPLE_W;

  localparam int LOG_FRAC    = 20;
  localparam int MANT_W      = 31;
  localparam int LOG_C_W     = 29;
  localparam logic [LOG_C_W-1:0] LOG_C = 29'd505044526;
  localparam int ROUND_SHIFT = 44 - LEVEL_FRAC_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [FRAME_CFG_W-1:0] FRAME_RESET = 17'd16384;
  localparam logic [GROUP_CFG_W-1:0] GROUP_RESET = 13'd512;

  typedef enum logic {
    REG_FRAME = 1'b0,
    REG_GROUP = 1'b1
  } slb_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] real_part;
    logic signed [SAMPLE_W-1:0] imag_part;
    logic                       add_en;
    logic                       first;
    logic                       emit;
    logic                       last;
    logic [BAND_W-1:0]          band;
  } slb_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ADDSQ,
    ST_ROOT,
    ST_ACCUM,
    ST_CHECK,
    ST_DIVIDE,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_CHK,
    ST_SCALE,
    ST_ROUND,
    ST_OUTPUT
  } slb_state_t;

endpackage

@@ rtl/slb_in_if.sv @@
// Input channel interface: one complex spectrum value per word.
// Depends on slb_pkg.
interface slb_in_if import slb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] real_part;
  logic signed [SAMPLE_W-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

@@ rtl/slb_out_if.sv @@
// Result channel interface: one band level per word.
// Depends on slb_pkg.
interface slb_out_if import slb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BAND_W-1:0]  band_index;
  logic [LEVEL_W-1:0] band_level;
  logic               last_band;

  modport source (output valid, output band_index, output band_level, output last_band,
                  input ready);
  modport sink   (input valid, input band_index, input band_level, input last_band,
                  output ready);
endinterface

@@ rtl/spectrum_band_log_averager.sv @@
// Spectrum band log averager: one value per word in; one level per whole band out.
// A first-half value runs a serial 28-digit square root in the back end; other values go
// straight to accumulation. A band end adds a serial divider, a leading-one search of one
// bit per cycle and 20 squarings. A 4-word queue decouples the input.
// Reset is synchronous, active low; registers return to frame_len 16384, group_len 512.
module spectrum_band_log_averager import slb_pkg::*; #(
  parameter int MAX_FRAME = 65536,
  parameter int MAX_GROUP = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  slb_in_if.sink             in_ch,
  slb_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int POS_W = $clog2(MAX_FRAME);
  localparam int FRM_W = POS_W + 1;
  localparam int GRP_W = $clog2(MAX_GROUP) + 1;
  localparam int OFF_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int SUM_W = MAG_W + CNT_W + 2;

  logic [FRAME_CFG_W-1:0] frame_len_r, frame_len_nxt;
  logic [GROUP_CFG_W-1:0] group_len_r, group_len_nxt;
  logic                   wr;
  slb_reg_t               sel;
  logic [FRM_W-1:0]       frame_eff;
  logic [GRP_W-1:0]       group_eff;

  logic      push, full, pop, q_valid;
  slb_item_t push_item, q_item;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = slb_reg_t'(paddr[2]);

  always_comb begin
    frame_len_nxt = frame_len_r;
    group_len_nxt = group_len_r;
    prdata        = '0;
    case (sel)
      REG_FRAME: begin
        prdata = PDATA_W'(frame_len_r);
        if (wr) begin
          frame_len_nxt = pwdata[FRAME_CFG_W-1:0];
        end
      end
      REG_GROUP: begin
        prdata = PDATA_W'(group_len_r);
        if (wr) begin
          group_len_nxt = pwdata[GROUP_CFG_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_RESET;
      group_len_r <= GROUP_RESET;
    end else begin
      frame_len_r <= frame_len_nxt;
      group_len_r <= group_len_nxt;
    end
  end

  // Out-of-range settings are clamped to the nearest supported length.
  always_comb begin
    if (frame_len_r < FRAME_CFG_W'(2)) begin
      frame_eff = FRM_W'(2);
    end else if (int'(frame_len_r) > MAX_FRAME) begin
      frame_eff = FRM_W'(MAX_FRAME);
    end else begin
      frame_eff = FRM_W'(frame_len_r);
    end
    if (group_len_r == '0) begin
      group_eff = GRP_W'(1);
    end else if (int'(group_len_r) > MAX_GROUP) begin
      group_eff = GRP_W'(MAX_GROUP);
    end else begin
      group_eff = GRP_W'(group_len_r);
    end
  end

  slb_front #(
    .POS_W(POS_W),
    .FRM_W(FRM_W),
    .GRP_W(GRP_W),
    .OFF_W(OFF_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (wr),
    .frame_eff (frame_eff),
    .group_eff (group_eff),
    .in_ch     (in_ch),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  slb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  slb_back #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/slb_front.sv @@
// Front end: accepts spectrum values, tracks frame position and band, classifies each word.
// Depends on slb_pkg and slb_in_if.
module slb_front import slb_pkg::*; #(
  parameter int POS_W = 16,
  parameter int FRM_W = 17,
  parameter int GRP_W = 13,
  parameter int OFF_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic [FRM_W-1:0] frame_eff,
  input  logic [GRP_W-1:0] group_eff,
  slb_in_if.sink           in_ch,
  output logic             push,
  output slb_item_t        push_item,
  input  logic             full
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [FRM_W-1:0]  bstart_r, bstart_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;

  logic             acc;
  logic [FRM_W:0]   band_end;
  logic [FRM_W+1:0] next_end;
  logic             whole;
  logic             last;
  logic             add_en;
  logic             off_last;
  logic [FRM_W-1:0] pos_inc;
  logic             wrap;

  assign in_ch.ready = !full;
  assign acc         = in_ch.valid && in_ch.ready;

  // A band counts only while it ends inside the frame.
  assign band_end = {1'b0, bstart_r} + (FRM_W+1)'(group_eff);
  assign next_end = {1'b0, band_end} + (FRM_W+2)'(group_eff);
  assign whole    = band_end <= {1'b0, frame_eff};
  assign last     = next_end > {2'b00, frame_eff};
  assign add_en   = FRM_W'(pos_r) < (frame_eff >> 1);
  assign off_last = GRP_W'(off_r) == group_eff - GRP_W'(1);
  assign pos_inc  = FRM_W'(pos_r) + FRM_W'(1);
  assign wrap     = pos_inc >= frame_eff;

  assign push                = acc && whole;
  assign push_item.real_part = in_ch.real_part;
  assign push_item.imag_part = in_ch.imag_part;
  assign push_item.add_en    = add_en;
  assign push_item.first     = off_r == '0;
  assign push_item.emit      = off_last;
  assign push_item.last      = last;
  assign push_item.band      = band_r;

  always_comb begin
    pos_nxt    = pos_r;
    off_nxt    = off_r;
    bstart_nxt = bstart_r;
    band_nxt   = band_r;
    if (restart) begin
      pos_nxt    = '0;
      off_nxt    = '0;
      bstart_nxt = '0;
      band_nxt   = '0;
    end else if (acc) begin
      if (wrap) begin
        pos_nxt    = '0;
        off_nxt    = '0;
        bstart_nxt = '0;
        band_nxt   = '0;
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
        if (whole) begin
          if (off_last) begin
            off_nxt    = '0;
            bstart_nxt = band_end[FRM_W-1:0];
            band_nxt   = band_r + BAND_W'(1);
          end else begin
            off_nxt = off_r + OFF_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      off_r    <= '0;
      bstart_r <= '0;
      band_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      off_r    <= off_nxt;
      bstart_r <= bstart_nxt;
      band_r   <= band_nxt;
    end
  end

`ifndef SYNTHESIS
  a_off_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    GRP_W'(off_r) < group_eff)
    else $error("band offset reached the band length");
  a_band_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && whole && off_last && !wrap && !restart) |=> (off_r == '0))
    else $error("band offset did not restart after the last word of a band");
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    FRM_W'(pos_r) < frame_eff)
    else $error("frame position ran past the frame length");
`endif

endmodule

@@ rtl/slb_fifo.sv @@
// Short queue of classified words between the front end and the arithmetic back end.
// Depends on slb_pkg.
module slb_fifo import slb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  slb_item_t push_item,
  output logic      full,
  input  logic      pop,
  output slb_item_t pop_item,
  output logic      not_empty
);

  slb_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue holds more words than its depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into a full queue");
`endif

endmodule

@@ rtl/slb_back.sv @@
// Back end: serial magnitude root, band accumulation, divider, log2 by squaring, scaling.
// Depends on slb_pkg and slb_out_if.
module slb_back import slb_pkg::*; #(
  parameter int CNT_W = 13,
  parameter int SUM_W = 43
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  slb_item_t q_item,
  output logic      pop,
  slb_out_if.source out_ch
);

  localparam int X_W    = SUM_W + 1;
  localparam int P_W    = $clog2(X_W);
  localparam int LG_W   = P_W + LOG_FRAC;
  localparam int SCL_W  = LG_W + LOG_C_W;
  localparam int HI_W   = SCL_W + 1 - ROUND_SHIFT;
  localparam int REM_W  = MAG_W + 1;
  localparam int STEP_W = $clog2(SUM_W + MAG_W + LOG_FRAC);

  slb_state_t state_r, state_nxt;

  slb_item_t           item_r, item_nxt;
  logic [SQ_W-1:0]     sqa_r, sqa_nxt, sqb_r, sqb_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [MAG_W-1:0]    root_r, root_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    drem_r, drem_nxt;
  logic [X_W-1:0]      x_r, x_nxt;
  logic [P_W-1:0]      p_r, p_nxt;
  logic [MANT_W-1:0]   m_r, m_nxt;
  logic [2*MANT_W-1:0] prod_r, prod_nxt;
  logic [LOG_FRAC-1:0] frac_r, frac_nxt;
  logic [SCL_W-1:0]    scl_r, scl_nxt;
  logic [LEVEL_W-1:0]  lvl_r, lvl_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [BAND_W-1:0]   oband_r, oband_nxt;
  logic [LEVEL_W-1:0]  olvl_r, olvl_nxt;
  logic                olast_r, olast_nxt;

  logic [SAMPLE_W-1:0] a_abs, b_abs;
  logic [REM_W+1:0]    rem2;
  logic [REM_W+1:0]    trial;
  logic [CNT_W:0]      dr2;
  logic [CNT_W:0]      ddiff;
  logic                dge;
  logic [SUM_W-1:0]    base_sum;
  logic [CNT_W-1:0]    base_cnt;
  logic [MANT_W:0]     sq_top;
  logic [LG_W-1:0]     lg;
  logic [SCL_W:0]      rnd;
  logic [HI_W-1:0]     hi;
  logic                out_free;

  assign out_free = !ovalid_r || out_ch.ready;

  assign a_abs = item_r.real_part[SAMPLE_W-1] ? (~item_r.real_part + 1'b1) : item_r.real_part;
  assign b_abs = item_r.imag_part[SAMPLE_W-1] ? (~item_r.imag_part + 1'b1) : item_r.imag_part;

  // One root digit per cycle.
  assign rem2  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = (REM_W+2)'({root_r, 2'b01});

  // One quotient bit per cycle.
  assign dr2   = {drem_r, quo_r[SUM_W-1]};
  assign ddiff = dr2 - {1'b0, cnt_r};
  assign dge   = dr2 >= {1'b0, cnt_r};

  assign base_sum = item_r.first ? '0 : sum_r;
  assign base_cnt = item_r.first ? '0 : cnt_r;

  assign sq_top = prod_r[2*MANT_W-1 -: MANT_W+1];
  assign lg     = {P_W'(p_r - P_W'(4)), frac_r};
  assign rnd    = {1'b0, scl_r} + ((SCL_W+1)'(1) << (ROUND_SHIFT - 1));
  assign hi     = rnd[SCL_W:ROUND_SHIFT];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_item.add_en ? ST_SQUARE : ST_ACCUM;
        end
      end
      ST_SQUARE: state_nxt = ST_ADDSQ;
      ST_ADDSQ:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (step_r == STEP_W'(MAG_W - 1)) begin
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM:  state_nxt = item_r.emit ? ST_CHECK : ST_IDLE;
      ST_CHECK:  state_nxt = (cnt_r == '0) ? ST_OUTPUT : ST_DIVIDE;
      ST_DIVIDE: begin
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (x_r[X_W-1]) begin
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: state_nxt = ST_SQ_CHK;
      ST_SQ_CHK: begin
        state_nxt = (step_r == STEP_W'(LOG_FRAC - 1)) ? ST_SCALE : ST_SQ_MUL;
      end
      ST_SCALE:  state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_OUTPUT;
      ST_OUTPUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    item_nxt   = item_r;
    sqa_nxt    = sqa_r;
    sqb_nxt    = sqb_r;
    rad_nxt    = rad_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    step_nxt   = step_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    drem_nxt   = drem_r;
    x_nxt      = x_r;
    p_nxt      = p_r;
    m_nxt      = m_r;
    prod_nxt   = prod_r;
    frac_nxt   = frac_r;
    scl_nxt    = scl_r;
    lvl_nxt    = lvl_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    oband_nxt  = oband_r;
    olvl_nxt   = olvl_r;
    olast_nxt  = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          item_nxt = q_item;
        end
      end
      ST_SQUARE: begin
        sqa_nxt = SQ_W'(a_abs) * SQ_W'(a_abs);
        sqb_nxt = SQ_W'(b_abs) * SQ_W'(b_abs);
      end
      ST_ADDSQ: begin
        rad_nxt  = {sqa_r + sqb_r, 8'h00};
        rem_nxt  = '0;
        root_nxt = '0;
        step_nxt = '0;
      end
      ST_ROOT: begin
        rad_nxt  = rad_r << 2;
        step_nxt = step_r + STEP_W'(1);
        if (rem2 >= trial) begin
          rem_nxt  = REM_W'(rem2 - trial);
          root_nxt = {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(rem2);
          root_nxt = {root_r[MAG_W-2:0], 1'b0};
        end
      end
      ST_ACCUM: begin
        if (item_r.add_en) begin
          sum_nxt = base_sum + SUM_W'(root_r);
          cnt_nxt = base_cnt + CNT_W'(1);
        end else begin
          sum_nxt = base_sum;
          cnt_nxt = base_cnt;
        end
      end
      ST_CHECK: begin
        lvl_nxt  = '0;
        quo_nxt  = sum_r;
        drem_nxt = '0;
        step_nxt = '0;
      end
      ST_DIVIDE: begin
        step_nxt = step_r + STEP_W'(1);
        drem_nxt = dge ? ddiff[CNT_W-1:0] : dr2[CNT_W-1:0];
        quo_nxt  = {quo_r[SUM_W-2:0], dge};
        x_nxt    = X_W'(quo_nxt) + X_W'(16);
        p_nxt    = P_W'(X_W - 1);
      end
      ST_NORM: begin
        // Leading-one search, one bit per cycle.
        if (x_r[X_W-1]) begin
          m_nxt    = x_r[X_W-1 -: MANT_W];
          frac_nxt = '0;
          step_nxt = '0;
        end else begin
          x_nxt = x_r << 1;
          p_nxt = p_r - P_W'(1);
        end
      end
      ST_SQ_MUL: begin
        prod_nxt = (2*MANT_W)'(m_r) * (2*MANT_W)'(m_r);
      end
      ST_SQ_CHK: begin
        step_nxt = step_r + STEP_W'(1);
        frac_nxt = {frac_r[LOG_FRAC-2:0], sq_top[MANT_W]};
        m_nxt    = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
      end
      ST_SCALE: begin
        scl_nxt = SCL_W'(lg) * SCL_W'(LOG_C);
      end
      ST_ROUND: begin
        lvl_nxt = (|hi[HI_W-1:LEVEL_W]) ? '1 : hi[LEVEL_W-1:0];
      end
      ST_OUTPUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oband_nxt  = item_r.band;
          olvl_nxt   = lvl_r;
          olast_nxt  = item_r.last;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    sqa_r   <= sqa_nxt;
    sqb_r   <= sqb_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    step_r  <= step_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    quo_r   <= quo_nxt;
    drem_r  <= drem_nxt;
    x_r     <= x_nxt;
    p_r     <= p_nxt;
    m_r     <= m_nxt;
    prod_r  <= prod_nxt;
    frac_r  <= frac_nxt;
    scl_r   <= scl_nxt;
    lvl_r   <= lvl_nxt;
    oband_r <= oband_nxt;
    olvl_r  <= olvl_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.band_index = oband_r;
  assign out_ch.band_level = olvl_r;
  assign out_ch.last_band  = olast_r;

`ifndef SYNTHESIS
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ_MUL) |-> m_r[MANT_W-1])
    else $error("log mantissa lost its leading one");
  a_root_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> (step_r < STEP_W'(MAG_W)))
    else $error("square root ran past its digit count");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == ST_IDLE) && q_valid)
    else $error("queue popped while the back end was busy");
`endif

endmodule
